>>> design/bq_pkg.sv
// Shared constants and types for the biquad IIR filter.
// No dependencies; every other design file refers to this package by scoped names.
package bq_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLE_BITS_DEFAULT    = 24;
    localparam int COEF_FRAC_BITS_DEFAULT = 30;
    localparam int DELAY_BITS_DEFAULT     = 40;

    // Coefficients are always 32-bit signed words.
    localparam int COEF_BITS = 32;

    // Configuration register map.
    localparam int NUM_REGS       = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_GAIN2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_GAIN1 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_GAIN2 = 3'd4;

    // Per-cycle control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic load;   // restart the accumulator from the init value
        logic issue;  // start a partial product this cycle
        logic sub;    // subtract this partial product
        logic hi;     // upper chunk of the operand, weighted by the chunk shift
    } mac_ctrl_t;

endpackage

>>> design/bq_if.sv
// Channel interfaces of the biquad IIR filter: sample input, sample output and
// configuration write. Depends on bq_pkg for default widths.
interface bq_in_if #(
    parameter int SAMPLE_BITS = bq_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bq_out_if #(
    parameter int SAMPLE_BITS = bq_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bq_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [bq_pkg::CFG_INDEX_BITS-1:0]     index;
    logic [bq_pkg::CFG_DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/bq_mac.sv
// Shared multiply-accumulate unit of the biquad filter: one registered
// coefficient-by-chunk multiplier feeding a wide accumulator. Depends on bq_pkg.
module bq_mac #(
    parameter int ACC_BITS   = 74,
    parameter int CHUNK_BITS = 21,
    parameter int LO_SHIFT   = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bq_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [ACC_BITS-1:0]            init,
    input  logic signed [bq_pkg::COEF_BITS-1:0]   coef,
    input  logic signed [CHUNK_BITS-1:0]          chunk,
    output logic signed [ACC_BITS-1:0]            acc
);

    localparam int PROD_BITS = bq_pkg::COEF_BITS + CHUNK_BITS;

    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] prod_next;
    logic                        prod_valid_reg;
    logic                        prod_sub_reg;
    logic                        prod_hi_reg;
    logic signed [ACC_BITS-1:0]  acc_reg;
    logic signed [ACC_BITS-1:0]  acc_next;
    logic signed [ACC_BITS-1:0]  term;
    logic signed [ACC_BITS-1:0]  addend;

    assign prod_next = coef * chunk;

    always_comb
    begin
        term   = prod_hi_reg ? (ACC_BITS'(prod_reg) <<< LO_SHIFT) : ACC_BITS'(prod_reg);
        addend = '0;
        if (prod_valid_reg)
        begin
            addend = prod_sub_reg ? -term : term;
        end
        acc_next = (ctrl.load ? init : acc_reg) + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_sub_reg   <= 1'b0;
            prod_hi_reg    <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.issue;
            prod_sub_reg   <= ctrl.sub;
            prod_hi_reg    <= ctrl.hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.load || prod_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> design/biquad_iir_filter.sv
// Top level of the biquad IIR filter: configuration registers, delay line,
// sequencer and output register. Depends on bq_pkg, bq_if.sv and bq_mac.
//
// One second-order IIR section in direct form II. Each input item is one
// signed sample; each produces exactly one filtered, saturated output item.
// The block computes w = x - fb_gain1*w1 - fb_gain2*w2 and then
// y = ff_gain0*w + ff_gain1*w1 + ff_gain2*w2, with all coefficients signed
// Q2.30 and both sums formed exactly, rounded half up and saturated (w to
// the delay word width, y to the sample width). A sample is accepted when
// the block is idle. The single shared multiplier sets the pace: each
// coefficient product is built from two partial products of the coefficient
// and one half of the delay word, ten in all, issued one per cycle, plus the
// pipeline drain and the delay line update. A finished result waits in the
// output register while the next sample is taken, and that sample's result
// waits in the finishing state until the earlier one is taken. Coefficient
// writes are taken every cycle and belong only to idle periods, which the
// user must keep to; the block does not enforce it. Writes to an index past
// the last register are dropped. After reset the block passes samples
// through unchanged.
module biquad_iir_filter #(
    parameter int SAMPLE_BITS    = bq_pkg::SAMPLE_BITS_DEFAULT,
    parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_BITS_DEFAULT,
    parameter int DELAY_BITS     = bq_pkg::DELAY_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bq_cfg_if.sink     cfg,
    bq_in_if.sink      sample_ch,
    bq_out_if.source   result_ch
);

    localparam int COEF_BITS  = bq_pkg::COEF_BITS;
    // Each delay word is split into an unsigned low half and a signed high half,
    // so the multiplier never needs to be wider than coefficient by chunk.
    localparam int LO_BITS    = DELAY_BITS / 2;
    localparam int HI_BITS    = DELAY_BITS - LO_BITS;
    localparam int CHUNK_BITS = HI_BITS + 1;
    // The accumulator holds any sum exactly, with two guard bits for three terms.
    localparam int WIDE_PROD  = COEF_BITS + DELAY_BITS;
    localparam int WIDE_X     = SAMPLE_BITS + COEF_FRAC_BITS;
    localparam int ACC_BITS   = ((WIDE_PROD > WIDE_X) ? WIDE_PROD : WIDE_X) + 2;

    localparam logic signed [ACC_BITS-1:0] HALF = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] W_MAX =
        {{(ACC_BITS - DELAY_BITS + 1){1'b0}}, {(DELAY_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] W_MIN = ~W_MAX;
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1 << COEF_FRAC_BITS);

    // Sequencer steps. Steps that load restart the accumulator.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_FB1_LO = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_FB1_HI = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_FB2_LO = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_FB2_HI = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_FF1_LO = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_FF1_HI = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_FF2_LO = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_FF2_HI = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_FF0_LO = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_FF0_HI = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_LAST   = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OPD_D1,
        OPD_D2,
        OPD_W
    } opd_sel_t;

    state_t                          state_reg;
    logic [STEP_BITS-1:0]            step_reg;
    logic signed [COEF_BITS-1:0]     coef_reg [bq_pkg::NUM_REGS];
    logic signed [SAMPLE_BITS-1:0]   x_reg;
    logic signed [DELAY_BITS-1:0]    w_reg;
    logic signed [DELAY_BITS-1:0]    w_next;
    logic signed [DELAY_BITS-1:0]    delay_one_reg;
    logic signed [DELAY_BITS-1:0]    delay_two_reg;
    logic                            out_valid_reg;
    logic signed [SAMPLE_BITS-1:0]   sample_out_reg;
    logic signed [SAMPLE_BITS-1:0]   y_next;

    bq_pkg::mac_ctrl_t                   mac_ctrl;
    logic [bq_pkg::CFG_INDEX_BITS-1:0]   coef_sel;
    opd_sel_t                            opd_sel;
    logic signed [DELAY_BITS-1:0]        opd_word;
    logic signed [CHUNK_BITS-1:0]        chunk;
    logic signed [COEF_BITS-1:0]         coef;
    logic signed [ACC_BITS-1:0]          init_val;
    logic signed [ACC_BITS-1:0]          acc;
    logic signed [ACC_BITS-1:0]          acc_shift;
    logic                                in_take;

    // Configuration registers. The port never stalls.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bq_pkg::NUM_REGS; i++)
            begin
                coef_reg[i] <= (i == bq_pkg::REG_FF_GAIN0) ? UNITY : '0;
            end
        end
        else if (cfg.valid && cfg.ready && (cfg.index < bq_pkg::NUM_REGS))
        begin
            coef_reg[cfg.index] <= cfg.data;
        end
    end

    // Step schedule. The feedback sum uses steps 0 to 3; step 4 already starts
    // the feedforward terms that do not need w, and step 5 captures w and
    // restarts the accumulator while the first feedforward product lands.
    always_comb
    begin
        mac_ctrl = '0;
        coef_sel = bq_pkg::REG_FF_GAIN0;
        opd_sel  = OPD_D1;
        if (state_reg == ST_RUN)
        begin
            unique case (step_reg)
                STEP_FB1_LO:
                begin
                    mac_ctrl = '{load: 1'b1, issue: 1'b1, sub: 1'b1, hi: 1'b0};
                    coef_sel = bq_pkg::REG_FB_GAIN1;
                end
                STEP_FB1_HI:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b1, hi: 1'b1};
                    coef_sel = bq_pkg::REG_FB_GAIN1;
                end
                STEP_FB2_LO:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b1, hi: 1'b0};
                    coef_sel = bq_pkg::REG_FB_GAIN2;
                    opd_sel  = OPD_D2;
                end
                STEP_FB2_HI:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b1, hi: 1'b1};
                    coef_sel = bq_pkg::REG_FB_GAIN2;
                    opd_sel  = OPD_D2;
                end
                STEP_FF1_LO:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b0, hi: 1'b0};
                    coef_sel = bq_pkg::REG_FF_GAIN1;
                end
                STEP_FF1_HI:
                begin
                    mac_ctrl = '{load: 1'b1, issue: 1'b1, sub: 1'b0, hi: 1'b1};
                    coef_sel = bq_pkg::REG_FF_GAIN1;
                end
                STEP_FF2_LO:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b0, hi: 1'b0};
                    coef_sel = bq_pkg::REG_FF_GAIN2;
                    opd_sel  = OPD_D2;
                end
                STEP_FF2_HI:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b0, hi: 1'b1};
                    coef_sel = bq_pkg::REG_FF_GAIN2;
                    opd_sel  = OPD_D2;
                end
                STEP_FF0_LO:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b0, hi: 1'b0};
                    opd_sel  = OPD_W;
                end
                STEP_FF0_HI:
                begin
                    mac_ctrl = '{load: 1'b0, issue: 1'b1, sub: 1'b0, hi: 1'b1};
                    opd_sel  = OPD_W;
                end
                default:
                begin
                    // The last step only drains the final product.
                    mac_ctrl = '0;
                end
            endcase
        end
    end

    // Operand selection and splitting into chunks.
    always_comb
    begin
        unique case (opd_sel)
            OPD_D1:  opd_word = delay_one_reg;
            OPD_D2:  opd_word = delay_two_reg;
            OPD_W:   opd_word = w_reg;
            default: opd_word = delay_one_reg;
        endcase
        if (mac_ctrl.hi)
        begin
            chunk = {opd_word[DELAY_BITS-1], opd_word[DELAY_BITS-1:LO_BITS]};
        end
        else
        begin
            chunk = CHUNK_BITS'({1'b0, opd_word[LO_BITS-1:0]});
        end
    end

    assign coef = coef_reg[coef_sel];

    // The feedback sum starts from the scaled sample plus the rounding half;
    // the feedforward sum starts from the rounding half alone.
    assign init_val = (step_reg == STEP_FB1_LO)
                      ? (ACC_BITS'(x_reg) <<< COEF_FRAC_BITS) + HALF
                      : HALF;

    bq_mac #(
        .ACC_BITS   (ACC_BITS),
        .CHUNK_BITS (CHUNK_BITS),
        .LO_SHIFT   (LO_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .init  (init_val),
        .coef  (coef),
        .chunk (chunk),
        .acc   (acc)
    );

    // Drop the fraction bits and clamp to the delay word and sample ranges.
    assign acc_shift = acc >>> COEF_FRAC_BITS;

    always_comb
    begin
        priority if (acc_shift > W_MAX)
        begin
            w_next = DELAY_BITS'(W_MAX);
        end
        else if (acc_shift < W_MIN)
        begin
            w_next = DELAY_BITS'(W_MIN);
        end
        else
        begin
            w_next = acc_shift[DELAY_BITS-1:0];
        end

        priority if (acc_shift > Y_MAX)
        begin
            y_next = SAMPLE_BITS'(Y_MAX);
        end
        else if (acc_shift < Y_MIN)
        begin
            y_next = SAMPLE_BITS'(Y_MIN);
        end
        else
        begin
            y_next = acc_shift[SAMPLE_BITS-1:0];
        end
    end

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign in_take         = sample_ch.valid && sample_ch.ready;

    // Sequencer, delay line and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            x_reg          <= '0;
            w_reg          <= '0;
            delay_one_reg  <= '0;
            delay_two_reg  <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            // In the finishing state the output register is handled below.
            if (out_valid_reg && result_ch.ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        x_reg     <= sample_ch.sample_in;
                        step_reg  <= STEP_FB1_LO;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == STEP_FF1_HI)
                    begin
                        w_reg <= w_next;
                    end
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_FINISH:
                begin
                    // Wait here only while an earlier result is still not taken.
                    if (!out_valid_reg || result_ch.ready)
                    begin
                        sample_out_reg <= y_next;
                        out_valid_reg  <= 1'b1;
                        delay_two_reg  <= delay_one_reg;
                        delay_one_reg  <= w_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = sample_out_reg;

    // A sample is taken only when idle, so the block is busy right after.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !sample_ch.ready)
        else $error("input accepted again right after a sample was taken");

    // A new result appears only out of the finishing state.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("output became valid outside the finishing state");

    // The delay line moves only when a result is written.
    a_delay_moves_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(state_reg == ST_FINISH) |-> ($stable(delay_one_reg) && $stable(delay_two_reg)))
        else $error("delay line changed while a sample was in progress");

    // The step counter never runs past the schedule.
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("sequencer step out of range");

endmodule
